FILE: sv/wbps_pkg.sv
`default_nettype none
package wbps_pkg;

  // sizes
  localparam int MaxPattern = 16;
  localparam int OffsetBits = 32;
  localparam int LenBits    = 5;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 64;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_WILDCARD     = 2'd2,
    CFG_LENGTH       = 2'd3
  } cfg_reg_t;

  // request payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } out_res_t;

endpackage
`default_nettype wire

FILE: sv/wildcard_byte_pattern_search_core.sv
`default_nettype none
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------
// in_       | input     | in_valid / in_ready    | in_data  (data_byte, last_byte)
// out_      | output    | out_valid / out_ready  | out_data (found, match_offset)
// cfg_      | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One byte per cycle while in_ready is high: the window shift, the 16 parallel byte
// compares and the offset subtract sit between the window and result registers.
// A result shows on out_ in the cycle after the byte that causes it is taken.
// in_ready drops only while a result waits in the result register and out_ready is low.
// Reset (rst_n low, synchronous) clears the window, the byte count, the match flag,
// the result valid flag and the configuration registers (pattern length to 1).
module wildcard_byte_pattern_search_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire wbps_pkg::in_req_t                      in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output wbps_pkg::out_res_t                          out_data,
  input  wire logic                                   cfg_we,
  input  wire logic [wbps_pkg::CfgIdxBits-1:0]        cfg_index,
  input  wire logic [wbps_pkg::CfgDataBits-1:0]       cfg_wdata
);
  import wbps_pkg::*;

  // configuration registers
  logic [63:0]         pat_low_r;
  logic [63:0]         pat_high_r;
  logic [15:0]         wild_r;
  logic [LenBits-1:0]  plen_r;

  // scan state
  logic [7:0]            recent_r [MaxPattern];
  logic [7:0]            recent_nxt [MaxPattern];
  logic [OffsetBits-1:0] seen_r, seen_nxt;
  logic                  reported_r, reported_nxt;

  // result register
  logic     out_valid_r, out_valid_nxt;
  out_res_t out_data_r, out_data_nxt;

  logic                  in_acc;
  logic [127:0]          pat_all;
  logic [7:0]            win [MaxPattern];
  logic [LenBits-1:0]    eff_len;
  logic [OffsetBits-1:0] seen_inc;
  logic                  enough;
  logic                  match;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pat_all   = {pat_high_r, pat_low_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      wild_r     <= '0;
      plen_r     <= LenBits'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LOW:  pat_low_r  <= cfg_wdata[63:0];
        CFG_PATTERN_HIGH: pat_high_r <= cfg_wdata[63:0];
        CFG_WILDCARD:     wild_r     <= cfg_wdata[15:0];
        CFG_LENGTH:       plen_r     <= cfg_wdata[LenBits-1:0];
        default: ;
      endcase
    end
  end

  // length in use: zero acts as one, clamp to the window depth
  always_comb begin
    if (plen_r == '0) begin
      eff_len = LenBits'(1);
    end else if (plen_r > LenBits'(MaxPattern)) begin
      eff_len = LenBits'(MaxPattern);
    end else begin
      eff_len = plen_r;
    end
  end

  // window after taking the incoming byte, newest at slot 0
  always_comb begin
    win[0] = in_data.data_byte;
    for (int i = 1; i < MaxPattern; i++) begin
      win[i] = recent_r[i-1];
    end
  end

  // saturating byte count
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + OffsetBits'(1);
  assign enough   = seen_inc >= OffsetBits'(eff_len);

  // parallel compare of each non-wildcard pattern slot within the length against its window byte
  always_comb begin
    logic [LenBits-1:0] idx;
    match = 1'b1;
    for (int k = 0; k < MaxPattern; k++) begin
      idx = eff_len - LenBits'(1) - LenBits'(k);
      if ((LenBits'(k) < eff_len) && !wild_r[k]) begin
        if (win[idx[3:0]] != pat_all[8*k +: 8]) begin
          match = 1'b0;
        end
      end
    end
  end

  // next scan state and result
  always_comb begin
    recent_nxt    = recent_r;
    seen_nxt      = seen_r;
    reported_nxt  = reported_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      recent_nxt = win;
      seen_nxt   = seen_inc;
      if (!reported_r && enough && match) begin
        reported_nxt               = 1'b1;
        out_valid_nxt              = 1'b1;
        out_data_nxt.found         = 1'b1;
        out_data_nxt.match_offset  = 32'(seen_inc - OffsetBits'(eff_len));
      end else if (in_data.last_byte && !reported_r) begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.found         = 1'b0;
        out_data_nxt.match_offset  = '0;
      end
      // final byte ends the scan
      if (in_data.last_byte) begin
        for (int i = 0; i < MaxPattern; i++) begin
          recent_nxt[i] = '0;
        end
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxPattern; i++) begin
        recent_r[i] <= '0;
      end
      seen_r      <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      recent_r    <= recent_nxt;
      seen_r      <= seen_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  // a not-found result carries a zero offset
  a_nf_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.match_offset == '0))
    else $error("not-found result with nonzero offset");

  // the final byte leaves a cleared scan
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) |=> (seen_r == '0 && !reported_r))
    else $error("scan state not cleared after final byte");

  // once a match is reported, later bytes raise no result
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && reported_r && !(out_valid_r && !out_ready)) |=> !out_valid_r)
    else $error("result after match already reported");

endmodule
`default_nettype wire
